// File: design/svcs_pkg.sv
// Shared types and codes for the sorted vector clock store.
package svcs_pkg;

    typedef enum logic [2:0] {
        ACT_INC       = 3'd0,
        ACT_MAX       = 3'd1,
        ACT_MIN       = 3'd2,
        ACT_MIN_EMPTY = 3'd3,
        ACT_CLEAR     = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        t_action action;
        logic    last;
        logic    commit;
        logic    do_ins;
    } t_cell_ctrl;

endpackage

// File: design/svcs_cell.sv
// One entry of the store: thread id, count, valid and seen bits, shifted in from the left.
module svcs_cell #(
    parameter int COUNT_BITS  = 32,
    parameter int THREAD_BITS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  svcs_pkg::t_cell_ctrl     i_ctrl,
    input  logic [THREAD_BITS-1:0]   i_tid,
    input  logic [COUNT_BITS-1:0]    i_cnt,
    input  logic                     i_left_below,
    input  logic                     i_left_valid,
    input  logic                     i_left_seen,
    input  logic [THREAD_BITS-1:0]   i_left_thread,
    input  logic [COUNT_BITS-1:0]    i_left_value,
    output logic                     o_valid,
    output logic                     o_seen,
    output logic [THREAD_BITS-1:0]   o_thread,
    output logic [COUNT_BITS-1:0]    o_value,
    output logic                     o_below,
    output logic                     o_hit
);
    import svcs_pkg::*;

    logic                   r_valid;
    logic                   n_valid;
    logic                   r_seen;
    logic                   n_seen;
    logic [THREAD_BITS-1:0] r_thread;
    logic [THREAD_BITS-1:0] n_thread;
    logic [COUNT_BITS-1:0]  r_value;
    logic [COUNT_BITS-1:0]  n_value;
    logic                   below;
    logic                   hit;
    logic                   at_pos;
    logic                   shift;

    assign below  = r_valid && (r_thread < i_tid);
    assign hit    = r_valid && (r_thread == i_tid);
    assign at_pos = !below && i_left_below;
    assign shift  = !i_left_below;

    always_comb begin
        n_valid  = r_valid;
        n_seen   = r_seen;
        n_thread = r_thread;
        n_value  = r_value;
        if (i_ctrl.commit) begin
            case (i_ctrl.action) inside
                ACT_INC, ACT_MAX: begin
                    if (i_ctrl.do_ins) begin
                        if (at_pos) begin
                            n_valid  = 1'b1;
                            n_seen   = 1'b0;
                            n_thread = i_tid;
                            n_value  = (i_ctrl.action == ACT_INC) ?
                                       COUNT_BITS'(1) : i_cnt;
                        end else if (shift) begin
                            n_valid  = i_left_valid;
                            n_seen   = i_left_seen;
                            n_thread = i_left_thread;
                            n_value  = i_left_value;
                        end
                    end else if (hit) begin
                        if (i_ctrl.action == ACT_INC) begin
                            if (r_value != '1) begin
                                n_value = r_value + 1'b1;
                            end
                        end else if (i_cnt > r_value) begin
                            n_value = i_cnt;
                        end
                    end
                end
                ACT_MIN: begin
                    if (hit) begin
                        if (i_cnt < r_value) begin
                            n_value = i_cnt;
                        end
                        n_seen = 1'b1;
                    end
                    if (i_ctrl.last) begin
                        if (!hit && !r_seen) begin
                            n_value = '0;
                        end
                        n_seen = 1'b0;
                    end
                end
                ACT_MIN_EMPTY: begin
                    n_value = '0;
                    n_seen  = 1'b0;
                end
                ACT_CLEAR: begin
                    n_valid = 1'b0;
                    n_seen  = 1'b0;
                end
                default: begin
                    n_valid = r_valid;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_seen  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_seen  <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_thread <= n_thread;
        r_value  <= n_value;
    end

    assign o_valid  = r_valid;
    assign o_seen   = r_seen;
    assign o_thread = r_thread;
    assign o_value  = r_value;
    assign o_below  = below;
    assign o_hit    = hit;

endmodule

// File: design/sorted_vector_clock_store_unit.sv
// Top level of the sorted vector clock store: item handshake, control and result register.
//
//  channel | signals                                   | carries
//  --------+-------------------------------------------+---------------------------------
//  in      | i_s_tvalid o_s_tready i_s_tdata/tuser/tlast| action, thread, count, last mark
//  out     | o_m_tvalid i_m_tready o_m_tdata o_m_tuser | thread, count, present, used, status
//
// Each item is registered on acceptance in S_IDLE; then, in S_EXEC, every cell compares
// and updates in parallel and the result register loads. No new item is taken in S_EXEC.
// The update cycle holds while the result register is still full and not taken.
// Reset clears the valid and seen bits and the entry count; no clearing pass.
module sorted_vector_clock_store_unit #(
    parameter int CAPACITY    = 16,
    parameter int COUNT_BITS  = 32,
    parameter int THREAD_BITS = 8
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_s_tvalid,
    output logic                                                o_s_tready,
    // thread_id, element_count
    input  logic [((THREAD_BITS+COUNT_BITS+7)/8)*8-1:0]         i_s_tdata,
    // action
    input  logic [2:0]                                          i_s_tuser,
    input  logic                                                i_s_tlast,
    output logic                                                o_m_tvalid,
    input  logic                                                i_m_tready,
    // result_thread, result_count, entry_present, entries_used
    output logic [((THREAD_BITS+COUNT_BITS+1+$clog2(CAPACITY+1)+7)/8)*8-1:0] o_m_tdata,
    // status
    output logic [1:0]                                          o_m_tuser
);
    import svcs_pkg::*;

    localparam int USED_BITS     = $clog2(CAPACITY + 1);
    localparam int OUT_DATA_BITS = ((THREAD_BITS + COUNT_BITS + 1 + USED_BITS + 7) / 8) * 8;

    t_state                 r_state;
    t_state                 n_state;
    t_action                r_action;
    logic [THREAD_BITS-1:0] r_tid;
    logic [COUNT_BITS-1:0]  r_cnt;
    logic                   r_last;
    logic [USED_BITS-1:0]   r_used;
    logic [USED_BITS-1:0]   n_used;

    logic                   r_out_valid;
    logic [THREAD_BITS-1:0] r_out_thread;
    logic [COUNT_BITS-1:0]  r_out_count;
    logic                   r_out_present;
    logic [USED_BITS-1:0]   r_out_used;
    t_status                r_out_status;

    logic                   accept;
    logic                   commit;
    logic                   full;
    logic                   any_hit;
    logic                   want_ins;
    logic                   do_ins;
    logic [COUNT_BITS-1:0]  sel_value;
    logic [COUNT_BITS-1:0]  res_count;
    logic                   res_present;
    t_status                res_status;
    t_cell_ctrl             ctrl;

    logic [CAPACITY-1:0]    cell_valid;
    logic [CAPACITY-1:0]    cell_seen;
    logic [CAPACITY-1:0]    cell_below;
    logic [CAPACITY-1:0]    cell_hit;
    logic [THREAD_BITS-1:0] cell_thread [CAPACITY];
    logic [COUNT_BITS-1:0]  cell_value  [CAPACITY];

    assign accept = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        commit     = 1'b0;
        unique case (r_state)
            S_IDLE: o_s_tready = 1'b1;
            S_EXEC: commit     = !r_out_valid || i_m_tready;
            default: o_s_tready = 1'b0;
        endcase
    end

    assign full     = (r_used == USED_BITS'(CAPACITY));
    assign any_hit  = |cell_hit;
    assign want_ins = ((r_action == ACT_INC) || (r_action == ACT_MAX)) && !any_hit;
    assign do_ins   = want_ins && !full;

    assign ctrl.action = r_action;
    assign ctrl.last   = r_last;
    assign ctrl.commit = commit;
    assign ctrl.do_ins = do_ins;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        if (k == 0) begin : g_head
            svcs_cell #(
                .COUNT_BITS  (COUNT_BITS),
                .THREAD_BITS (THREAD_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (ctrl),
                .i_tid         (r_tid),
                .i_cnt         (r_cnt),
                .i_left_below  (1'b1),
                .i_left_valid  (1'b0),
                .i_left_seen   (1'b0),
                .i_left_thread ('0),
                .i_left_value  ('0),
                .o_valid       (cell_valid[k]),
                .o_seen        (cell_seen[k]),
                .o_thread      (cell_thread[k]),
                .o_value       (cell_value[k]),
                .o_below       (cell_below[k]),
                .o_hit         (cell_hit[k])
            );
        end else begin : g_body
            svcs_cell #(
                .COUNT_BITS  (COUNT_BITS),
                .THREAD_BITS (THREAD_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (ctrl),
                .i_tid         (r_tid),
                .i_cnt         (r_cnt),
                .i_left_below  (cell_below[k-1]),
                .i_left_valid  (cell_valid[k-1]),
                .i_left_seen   (cell_seen[k-1]),
                .i_left_thread (cell_thread[k-1]),
                .i_left_value  (cell_value[k-1]),
                .o_valid       (cell_valid[k]),
                .o_seen        (cell_seen[k]),
                .o_thread      (cell_thread[k]),
                .o_value       (cell_value[k]),
                .o_below       (cell_below[k]),
                .o_hit         (cell_hit[k])
            );
        end
    end

    always_comb begin
        sel_value = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            sel_value = sel_value | (cell_hit[k] ? cell_value[k] : '0);
        end
    end

    always_comb begin
        res_status  = ST_OK;
        res_present = any_hit ? (r_action != ACT_CLEAR) : do_ins;
        res_count   = sel_value;
        n_used      = r_used;
        case (r_action)
            ACT_INC: begin
                if (any_hit) begin
                    if (sel_value == '1) begin
                        res_status = ST_OVERFLOW;
                    end else begin
                        res_count = sel_value + 1'b1;
                    end
                end else begin
                    res_count = COUNT_BITS'(1);
                end
            end
            ACT_MAX: begin
                if (!any_hit || (r_cnt > sel_value)) begin
                    res_count = r_cnt;
                end
            end
            ACT_MIN: begin
                if (r_cnt < sel_value) begin
                    res_count = r_cnt;
                end
            end
            ACT_MIN_EMPTY: res_count = '0;
            ACT_CLEAR: begin
                res_count = '0;
                n_used    = '0;
            end
            default: res_count = sel_value;
        endcase
        if (want_ins && full) begin
            res_status = ST_FULL;
        end
        if (do_ins) begin
            n_used = r_used + 1'b1;
        end
        if (!res_present) begin
            res_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_used      <= n_used;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= t_action'(i_s_tuser);
            r_tid    <= i_s_tdata[THREAD_BITS-1:0];
            r_cnt    <= i_s_tdata[THREAD_BITS+COUNT_BITS-1:THREAD_BITS];
            r_last   <= i_s_tlast;
        end
        if (commit) begin
            r_out_thread  <= r_tid;
            r_out_count   <= res_count;
            r_out_present <= res_present;
            r_out_used    <= n_used;
            r_out_status  <= res_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_BITS'({r_out_used, r_out_present, r_out_count, r_out_thread});
    assign o_m_tuser  = r_out_status;

`ifndef SYNTH
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_BITS'(CAPACITY))
        else $error("entry count above capacity");

    a_used_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(cell_valid) == int'(r_used))
        else $error("entry count differs from valid cells");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cell_hit))
        else $error("thread id held by more than one cell");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_FULL)) |-> (r_out_used == USED_BITS'(CAPACITY)))
        else $error("full status with free entries");

    a_commit_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_valid)
        else $error("update without result");
`endif

endmodule
